@@ sv/css_pkg.sv @@
// Package for the cursor sequence store: word types, operation and status codes,
// and the command set of the cell row. It depends on nothing else.
package css_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 4;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 5;
  localparam int COUNT_W  = 6;
  localparam int STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_START    = 4'd0,
    OP_END      = 4'd1,
    OP_LAST     = 4'd2,
    OP_ADVANCE  = 4'd3,
    OP_RETREAT  = 4'd4,
    OP_INSERT   = 4'd5,
    OP_ATTACH   = 4'd6,
    OP_REMOVE   = 4'd7,
    OP_INSFRONT = 4'd8,
    OP_ATTBACK  = 4'd9,
    OP_REMFRONT = 4'd10,
    OP_READ     = 4'd11
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What every cell does on the update cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  current_value;
    logic                cursor_valid;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
  } out_word_t;

endpackage

@@ sv/cursor_sequence_store.sv @@
// Top level of the cursor sequence store: control state machine and the row of
// css_cell slots. Depends on css_pkg and css_cell.

// An ordered list of up to CAPACITY_ITEMS words with a cursor. A word is taken
// when start is high and busy is low, and passes through capture, an update in
// which the whole cell row shifts in parallel to open or close a gap where the
// operation calls for one, and a gather of the cursor and read slots into the
// result register. The result then shows on out_word with out_strobe high for
// exactly one cycle; it cannot be held off, so capture it on that cycle. busy
// falls in the same cycle, so the next word may follow at once. Reset clears
// every slot directly; no clearing pass follows it.
module cursor_sequence_store #(
  parameter int CAPACITY_ITEMS = css_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH     = css_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  css_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output css_pkg::out_word_t out_word
);
  import css_pkg::*;

  localparam int CW = (CAPACITY_ITEMS > 1) ? $clog2(CAPACITY_ITEMS) : 1;
  localparam int NW = $clog2(CAPACITY_ITEMS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e                state_r;
  logic [OP_W-1:0]       op_r;
  logic [DATA_WIDTH-1:0] value_r;
  logic [INDEX_W-1:0]    index_r;
  logic [CW-1:0]         cur_r;
  logic [CW-1:0]         cur_nxt;
  logic [NW-1:0]         cnt_r;
  logic [NW-1:0]         cnt_nxt;
  status_e               status_r;
  status_e               status_nxt;
  logic                  out_strobe_r;
  out_word_t             out_r;

  cell_mode_e            mode;
  cell_mode_e            mode_dec;
  logic [CW-1:0]         pos;

  logic                  full;
  logic                  empty;
  logic                  cvalid;

  logic [DATA_WIDTH-1:0] vals      [CAPACITY_ITEMS];
  logic [DATA_WIDTH-1:0] cur_parts [CAPACITY_ITEMS];
  logic [DATA_WIDTH-1:0] rd_parts  [CAPACITY_ITEMS];
  logic [DATA_WIDTH-1:0] cur_sel;
  logic [DATA_WIDTH-1:0] rd_sel;

  assign full   = (cnt_r == NW'(CAPACITY_ITEMS));
  assign empty  = (cnt_r == '0);
  assign cvalid = (NW'(cur_r) < cnt_r);

  // Decode of the captured operation against the present cursor and count.
  always_comb begin
    cur_nxt    = cur_r;
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    mode_dec   = CELL_HOLD;
    pos        = '0;
    case (op_r)
      OP_START: cur_nxt = '0;
      OP_END: cur_nxt = empty ? '0 : CW'(cnt_r - NW'(1));
      OP_LAST: cur_nxt = CW'(CAPACITY_ITEMS - 1);
      OP_ADVANCE: begin
        if (cur_r != CW'(CAPACITY_ITEMS - 1)) begin
          cur_nxt = cur_r + CW'(1);
        end
      end
      OP_RETREAT: begin
        if (cur_r != '0) begin
          cur_nxt = cur_r - CW'(1);
        end
      end
      OP_INSERT, OP_INSFRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          pos      = (op_r == OP_INSERT && cvalid) ? cur_r : '0;
          mode_dec = CELL_OPEN;
          cnt_nxt  = cnt_r + NW'(1);
          cur_nxt  = pos;
        end
      end
      OP_ATTACH, OP_ATTBACK: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          // Attach at the back lands at the count, which is slot 0 when empty.
          if (op_r == OP_ATTACH && cvalid) begin
            pos = cur_r + CW'(1);
          end else begin
            pos = CW'(cnt_r);
          end
          mode_dec = CELL_OPEN;
          cnt_nxt  = cnt_r + NW'(1);
          cur_nxt  = pos;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (cvalid) begin
          pos      = cur_r;
          mode_dec = CELL_CLOSE;
          cnt_nxt  = cnt_r - NW'(1);
        end
      end
      OP_REMFRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          pos      = '0;
          mode_dec = CELL_CLOSE;
          cnt_nxt  = cnt_r - NW'(1);
          cur_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign mode = (state_r == S_EXEC) ? mode_dec : CELL_HOLD;

  for (genvar i = 0; i < CAPACITY_ITEMS; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end
    if (i == CAPACITY_ITEMS - 1) begin : g_last
      assign right_val = '0;
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    css_cell #(
      .DW  (DATA_WIDTH),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .mode      (mode),
      .pos       (pos),
      .data      (value_r),
      .left_val  (left_val),
      .right_val (right_val),
      .cursor    (cur_r),
      .rd_index  (index_r),
      .val       (vals[i]),
      .cur_part  (cur_parts[i]),
      .rd_part   (rd_parts[i])
    );
  end

  // At most one cell matches each selector, so an OR gathers the word.
  always_comb begin
    cur_sel = '0;
    rd_sel  = '0;
    for (int i = 0; i < CAPACITY_ITEMS; i++) begin
      cur_sel = cur_sel | cur_parts[i];
      rd_sel  = rd_sel | rd_parts[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      cnt_r        <= '0;
      status_r     <= ST_OK;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          cur_r    <= cur_nxt;
          cnt_r    <= cnt_nxt;
          status_r <= status_nxt;
          state_r  <= S_RESP;
        end
        S_RESP: begin
          out_r.count         <= COUNT_W'(cnt_r);
          out_r.current_value <= VALUE_W'(cur_sel);
          out_r.cursor_valid  <= cvalid;
          out_r.read_value    <= (op_r == OP_READ) ? VALUE_W'(rd_sel) : '0;
          out_r.status        <= status_r;
          out_strobe_r        <= 1'b1;
          state_r             <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      op_r    <= in_word.op;
      value_r <= DATA_WIDTH'(in_word.value);
      index_r <= in_word.index;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(CAPACITY_ITEMS))
    else $error("element count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == S_EXEC))
    else $error("accepted word did not enter the update cycle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && full) |=> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) - NW'(1)))
    else $error("count grew on a full store");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_strobe) |-> state_r == S_IDLE)
    else $error("result shown while a word is in progress");
`endif

endmodule

@@ sv/css_cell.sv @@
// One slot of the cursor sequence store. It holds one data word and takes its
// neighbor's word, or the new data word at the gap position, when the row opens or closes a gap. Depends on css_pkg.
module css_cell #(
  parameter int DW  = 32,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  css_pkg::cell_mode_e                 mode,
  input  logic [CW-1:0]                       pos,
  input  logic [DW-1:0]                       data,
  input  logic [DW-1:0]                       left_val,
  input  logic [DW-1:0]                       right_val,
  input  logic [CW-1:0]                       cursor,
  input  logic [css_pkg::INDEX_W-1:0]         rd_index,
  output logic [DW-1:0]                       val,
  output logic [DW-1:0]                       cur_part,
  output logic [DW-1:0]                       rd_part
);
  import css_pkg::*;

  logic [DW-1:0] val_r;
  logic [DW-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (mode)
      CELL_OPEN: begin
        if (IDX > int'(pos)) begin
          val_nxt = left_val;
        end else if (IDX == int'(pos)) begin
          val_nxt = data;
        end
      end
      CELL_CLOSE: begin
        if (IDX >= int'(pos)) begin
          val_nxt = right_val;
        end
      end
      default: begin
      end
    endcase
  end

  // Slots at or above the count always hold zero, so no range check is
  // needed on the read-out side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val      = val_r;
  assign cur_part = (cursor == CW'(IDX)) ? val_r : '0;
  assign rd_part  = (int'(rd_index) == IDX) ? val_r : '0;

endmodule
